// ===== sv/amst_pkg.sv =====
`default_nettype none

package amst_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int AGE_W  = SLOT_W;

  localparam int FUNC_W  = 4;
  localparam int MASK_W  = 16;
  localparam int INDEX_W = 4;
  localparam int LEN_W   = 8;
  localparam int RSLOT_W = 4;

  localparam int          APB_DW      = 32;
  localparam int          APB_AW      = 3;
  localparam int          REG_COUNT   = 1;
  localparam logic [0:0]  REG_MAX_LEN = 1'b0;
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 8'd32;

  typedef enum logic [1:0] {
    KIND_FREE = 2'd0,
    KIND_NET  = 2'd1,
    KIND_DATA = 2'd2
  } kind_e;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD_NET_AGE = 4'd0,
    FN_ADD_NET     = 4'd1,
    FN_ADD_DATA    = 4'd2,
    FN_FIND_NET    = 4'd3,
    FN_FIND_DATA   = 4'd4,
    FN_ERASE       = 4'd5,
    FN_SET_CH      = 4'd6,
    FN_CLEAR_CH    = 4'd7,
    FN_AGE         = 4'd8
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_AGE,
    ST_FIND,
    ST_UPDATE,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// ===== sv/amst_if.sv =====
`default_nettype none

interface amst_req_if;
  logic                          valid;
  logic                          ready;
  logic [amst_pkg::FUNC_W-1:0]   func;
  logic [amst_pkg::MASK_W-1:0]   channel_mask;
  logic [amst_pkg::INDEX_W-1:0]  slot_index;
  logic [amst_pkg::LEN_W-1:0]    frame_length;

  modport source (output valid, func, channel_mask, slot_index, frame_length, input ready);
  modport sink   (input valid, func, channel_mask, slot_index, frame_length, output ready);
endinterface

interface amst_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [amst_pkg::RSLOT_W-1:0]  result_slot;
  logic                          found;
  logic                          table_full;

  modport source (output valid, result_slot, found, table_full, input ready);
  modport sink   (input valid, result_slot, found, table_full, output ready);
endinterface

`default_nettype wire

// ===== sv/aged_message_slot_table_top.sv =====
// Channel  Dir  Handshake             Beat
// req_i    in   valid/ready           func, channel_mask, slot_index, frame_length
// rsp_o    out  valid/ready           result_slot, found, table_full
// cfg      in   APB, pready tied high max_frame_length at word 0
//
// One request at a time; req_i.ready is high only while the sequencer is idle.
// Each request: accept, scan, done. Scan: add visits 1..SLOTS slots, plus SLOTS for the
// add-with-age pass; find, age: SLOTS; erase/set/clear: 1; rejected add, bad func: none.
// All scans step one slot per cycle through a single slot read/modify/write unit.
// Reset clears the whole slot table in flip-flops at once; no clearing pass.
// A stalled rsp_o holds its beat; the next finished beat waits in the done state.
`default_nettype none

module aged_message_slot_table_top (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  amst_req_if.sink                     req_i,
  amst_rsp_if.source                   rsp_o,
  input  wire                          psel_i,
  input  wire                          penable_i,
  input  wire                          pwrite_i,
  input  wire [amst_pkg::APB_AW-1:0]   paddr_i,
  input  wire [amst_pkg::APB_DW-1:0]   pwdata_i,
  output logic [amst_pkg::APB_DW-1:0]  prdata_o,
  output logic                         pready_o
);

  localparam int SW = amst_pkg::SLOT_W;
  localparam int AW = amst_pkg::AGE_W;
  localparam int MW = amst_pkg::MASK_W;
  localparam logic [SW-1:0] LAST    = SW'(amst_pkg::SLOTS - 1);
  localparam logic [AW-1:0] AGE_TOP = AW'(amst_pkg::SLOTS - 1);

  amst_pkg::kind_e           kind_q [amst_pkg::SLOTS];
  logic [MW-1:0]             chan_q [amst_pkg::SLOTS];
  logic [AW-1:0]             age_q  [amst_pkg::SLOTS];

  amst_pkg::state_e          state_q, state_d;
  logic [SW-1:0]             cnt_q, cnt_d;
  amst_pkg::func_e           func_q, func_d;
  logic [MW-1:0]             mask_q, mask_d;
  logic [SW-1:0]             idx_q, idx_d;
  logic [SW-1:0]             best_q, best_d;
  logic [AW-1:0]             best_age_q, best_age_d;
  logic                      hit_q, hit_d;
  logic                      full_q, full_d;
  logic [amst_pkg::LEN_W-1:0] max_len_q;

  logic                      out_valid_q;
  logic [amst_pkg::RSLOT_W-1:0] out_slot_q;
  logic                      out_found_q;
  logic                      out_full_q;

  logic                      accept;
  logic                      out_load;
  logic                      cfg_wr;
  logic                      idx_ok;
  logic                      too_long;
  amst_pkg::func_e           in_func;

  logic [SW-1:0]             rd_addr;
  amst_pkg::kind_e           rd_kind;
  logic [MW-1:0]             rd_chan;
  logic [AW-1:0]             rd_age;
  logic                      wr_en;
  logic [SW-1:0]             wr_addr;
  amst_pkg::kind_e           wr_kind;
  logic [MW-1:0]             wr_chan;
  logic [AW-1:0]             wr_age;
  amst_pkg::kind_e           want_kind;
  logic                      match;

  assign in_func  = amst_pkg::func_e'(req_i.func);
  assign accept   = req_i.valid && req_i.ready;
  assign idx_ok   = 32'(req_i.slot_index) < amst_pkg::SLOTS;
  assign too_long = req_i.frame_length > max_len_q;
  assign out_load = (state_q == amst_pkg::ST_DONE) && (!out_valid_q || rsp_o.ready);

  assign req_i.ready       = (state_q == amst_pkg::ST_IDLE);
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.result_slot = out_slot_q;
  assign rsp_o.found       = out_found_q;
  assign rsp_o.table_full  = out_full_q;

  assign cfg_wr   = psel_i && penable_i && pwrite_i && pready_o;
  assign pready_o = 1'b1;
  always_comb begin
    prdata_o = '0;
    if (paddr_i[amst_pkg::APB_AW-1] == amst_pkg::REG_MAX_LEN) begin
      prdata_o = amst_pkg::APB_DW'(max_len_q);
    end
  end

  assign rd_addr   = (state_q == amst_pkg::ST_UPDATE) ? idx_q : cnt_q;
  assign rd_kind   = kind_q[rd_addr];
  assign rd_chan   = chan_q[rd_addr];
  assign rd_age    = age_q[rd_addr];
  assign want_kind = (func_q == amst_pkg::FN_FIND_DATA) ? amst_pkg::KIND_DATA
                                                         : amst_pkg::KIND_NET;
  assign match     = (rd_kind == want_kind) && ((rd_chan & mask_q) != '0) &&
                     (!hit_q || (rd_age < best_age_q));

  always_comb begin
    state_d = state_q;
    case (state_q)
      amst_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_func)
            amst_pkg::FN_ADD_NET_AGE,
            amst_pkg::FN_ADD_NET,
            amst_pkg::FN_ADD_DATA: state_d = too_long ? amst_pkg::ST_DONE : amst_pkg::ST_ALLOC;
            amst_pkg::FN_FIND_NET,
            amst_pkg::FN_FIND_DATA: state_d = amst_pkg::ST_FIND;
            amst_pkg::FN_ERASE,
            amst_pkg::FN_SET_CH,
            amst_pkg::FN_CLEAR_CH: state_d = idx_ok ? amst_pkg::ST_UPDATE : amst_pkg::ST_DONE;
            amst_pkg::FN_AGE: state_d = amst_pkg::ST_AGE;
            default: state_d = amst_pkg::ST_DONE;
          endcase
        end
      end
      amst_pkg::ST_ALLOC: begin
        if (rd_kind == amst_pkg::KIND_FREE || cnt_q == LAST) begin
          state_d = (func_q == amst_pkg::FN_ADD_NET_AGE) ? amst_pkg::ST_AGE
                                                          : amst_pkg::ST_DONE;
        end
      end
      amst_pkg::ST_AGE,
      amst_pkg::ST_FIND: begin
        if (cnt_q == LAST) begin
          state_d = amst_pkg::ST_DONE;
        end
      end
      amst_pkg::ST_UPDATE: state_d = amst_pkg::ST_DONE;
      amst_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = amst_pkg::ST_IDLE;
        end
      end
      default: state_d = amst_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d      = cnt_q;
    func_d     = func_q;
    mask_d     = mask_q;
    idx_d      = idx_q;
    best_d     = best_q;
    best_age_d = best_age_q;
    hit_d      = hit_q;
    full_d     = full_q;
    wr_en      = 1'b0;
    wr_addr    = rd_addr;
    wr_kind    = rd_kind;
    wr_chan    = rd_chan;
    wr_age     = rd_age;
    case (state_q)
      amst_pkg::ST_IDLE: begin
        if (accept) begin
          func_d = in_func;
          mask_d = req_i.channel_mask;
          idx_d  = SW'(req_i.slot_index);
          best_d = '0;
          hit_d  = 1'b0;
          full_d = 1'b0;
          cnt_d  = '0;
        end
      end
      amst_pkg::ST_ALLOC: begin
        wr_kind = (func_q == amst_pkg::FN_ADD_DATA) ? amst_pkg::KIND_DATA
                                                     : amst_pkg::KIND_NET;
        wr_chan = mask_q;
        wr_age  = AGE_TOP;
        if (rd_kind == amst_pkg::KIND_FREE) begin
          wr_en  = 1'b1;
          wr_addr = cnt_q;
          best_d = cnt_q;
          hit_d  = 1'b1;
          cnt_d  = '0;
        end else if (cnt_q == LAST) begin
          wr_en   = 1'b1;
          wr_addr = '0;
          best_d  = '0;
          hit_d   = 1'b1;
          full_d  = 1'b1;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + SW'(1);
        end
      end
      amst_pkg::ST_AGE: begin
        wr_en = 1'b1;
        if (rd_kind != amst_pkg::KIND_FREE) begin
          if (rd_age == '0) begin
            if (rd_chan == '0) begin
              wr_kind = amst_pkg::KIND_FREE;
            end
          end else begin
            wr_age = rd_age - AW'(1);
          end
        end
        cnt_d = (cnt_q == LAST) ? '0 : cnt_q + SW'(1);
      end
      amst_pkg::ST_FIND: begin
        if (match) begin
          best_d     = cnt_q;
          best_age_d = rd_age;
          hit_d      = 1'b1;
        end
        cnt_d = (cnt_q == LAST) ? '0 : cnt_q + SW'(1);
      end
      amst_pkg::ST_UPDATE: begin
        wr_en = 1'b1;
        case (func_q)
          amst_pkg::FN_ERASE: begin
            wr_kind = amst_pkg::KIND_FREE;
            wr_chan = '0;
          end
          amst_pkg::FN_SET_CH:   wr_chan = rd_chan | mask_q;
          amst_pkg::FN_CLEAR_CH: wr_chan = rd_chan & ~mask_q;
          default:               wr_en   = 1'b0;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= amst_pkg::ST_IDLE;
      cnt_q       <= '0;
      hit_q       <= 1'b0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
      max_len_q   <= amst_pkg::MAX_LEN_RESET;
      for (int i = 0; i < amst_pkg::SLOTS; i++) begin
        kind_q[i] <= amst_pkg::KIND_FREE;
        chan_q[i] <= '0;
        age_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      hit_q   <= hit_d;
      full_q  <= full_d;
      if (cfg_wr && paddr_i[amst_pkg::APB_AW-1] == amst_pkg::REG_MAX_LEN) begin
        max_len_q <= pwdata_i[amst_pkg::LEN_W-1:0];
      end
      if (wr_en) begin
        kind_q[wr_addr] <= wr_kind;
        chan_q[wr_addr] <= wr_chan;
        age_q[wr_addr]  <= wr_age;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    mask_q     <= mask_d;
    idx_q      <= idx_d;
    best_q     <= best_d;
    best_age_q <= best_age_d;
    if (out_load) begin
      out_slot_q  <= hit_q ? amst_pkg::RSLOT_W'(best_q) : '0;
      out_found_q <= hit_q;
      out_full_q  <= full_q;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !req_i.ready)
    else $error("request taken while sequencer busy");

  a_idle_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == amst_pkg::ST_IDLE) |-> (cnt_q == '0))
    else $error("scan counter not parked at zero");

  a_full_implies_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_full_q || out_found_q))
    else $error("table_full without found");

  a_beat_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == amst_pkg::ST_DONE))
    else $error("response beat loaded outside done state");
`endif

endmodule

`default_nettype wire

// ===== sim/amst_slot_checker.sv =====
module amst_slot_checker
  import amst_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  amst_req_if               req_i,
  amst_rsp_if               rsp_i,
  input  wire               psel_i,
  input  wire               penable_i,
  input  wire               pwrite_i,
  input  wire [APB_AW-1:0]  paddr_i,
  input  wire [APB_DW-1:0]  pwdata_i,
  input  wire               pready_i,
  output int                mismatch_o,
  output int                outstanding_o
);

  localparam logic [APB_AW-1:0] MAX_LEN_ADDR = {REG_MAX_LEN, 2'b00};

  typedef struct packed {
    logic [RSLOT_W-1:0] slot;
    logic               found;
    logic               full;
  } slot_rsp_t;

  kind_e              slot_kind [SLOTS];
  logic [MASK_W-1:0]  slot_chan [SLOTS];
  logic [AGE_W-1:0]   slot_age  [SLOTS];
  logic [LEN_W-1:0]   len_limit;

  slot_rsp_t          awaited_rsp_q [$];
  slot_rsp_t          next_rsp;
  slot_rsp_t          oldest_rsp;
  int                 fail_total;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[chk] %s mismatch: got %0d, expected %0d at %0t", what, got, want, $time);
    fail_total++;
  endtask

  task automatic run_aging_pass();
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_kind[i] != KIND_FREE) begin
        if (slot_age[i] == '0) begin
          if (slot_chan[i] == '0) slot_kind[i] = KIND_FREE;
        end else begin
          slot_age[i] = slot_age[i] - 1'b1;
        end
      end
    end
  endtask

  task automatic predict_slot_op(input logic [FUNC_W-1:0] f, input logic [MASK_W-1:0] m,
                                 input logic [INDEX_W-1:0] s, input logic [LEN_W-1:0] l,
                                 output slot_rsp_t r);
    int    pick;
    int    min_age;
    logic  hit;
    logic  full;
    kind_e want_kind;
    r = '0;
    case (f)
      FN_ADD_NET_AGE, FN_ADD_NET, FN_ADD_DATA: begin
        if (l <= len_limit) begin
          pick = 0;
          full = 1'b1;
          for (int i = SLOTS - 1; i >= 0; i--) begin
            if (slot_kind[i] == KIND_FREE) begin
              pick = i;
              full = 1'b0;
            end
          end
          slot_kind[pick] = (f == FN_ADD_DATA) ? KIND_DATA : KIND_NET;
          slot_chan[pick] = m;
          slot_age[pick]  = AGE_W'(SLOTS - 1);
          r.slot  = RSLOT_W'(pick);
          r.found = 1'b1;
          r.full  = full;
          if (f == FN_ADD_NET_AGE) run_aging_pass();
        end
      end
      FN_FIND_NET, FN_FIND_DATA: begin
        want_kind = (f == FN_FIND_NET) ? KIND_NET : KIND_DATA;
        min_age = SLOTS;
        hit = 1'b0;
        pick = 0;
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_kind[i] == want_kind && (slot_chan[i] & m) != '0 &&
              int'(slot_age[i]) < min_age) begin
            min_age = slot_age[i];
            pick = i;
            hit = 1'b1;
          end
        end
        r.slot  = hit ? RSLOT_W'(pick) : '0;
        r.found = hit;
      end
      FN_ERASE: begin
        if (int'(s) < SLOTS) begin
          slot_kind[s] = KIND_FREE;
          slot_chan[s] = '0;
        end
      end
      FN_SET_CH: begin
        if (int'(s) < SLOTS) slot_chan[s] = slot_chan[s] | m;
      end
      FN_CLEAR_CH: begin
        if (int'(s) < SLOTS) slot_chan[s] = slot_chan[s] & ~m;
      end
      FN_AGE: begin
        run_aging_pass();
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_limit = MAX_LEN_RESET;
      for (int i = 0; i < SLOTS; i++) begin
        slot_kind[i] = KIND_FREE;
        slot_chan[i] = '0;
        slot_age[i]  = '0;
      end
      awaited_rsp_q.delete();
      fail_total = 0;
      mismatch_o <= 0;
      outstanding_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == MAX_LEN_ADDR) begin
        len_limit = pwdata_i[LEN_W-1:0];
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (awaited_rsp_q.size() == 0) begin
          report_mismatch("unexpected beat", rsp_i.result_slot, 0);
        end else begin
          oldest_rsp = awaited_rsp_q.pop_front();
          if (rsp_i.result_slot !== oldest_rsp.slot)
            report_mismatch("result_slot", rsp_i.result_slot, oldest_rsp.slot);
          if (rsp_i.found !== oldest_rsp.found)
            report_mismatch("found", rsp_i.found, oldest_rsp.found);
          if (rsp_i.table_full !== oldest_rsp.full)
            report_mismatch("table_full", rsp_i.table_full, oldest_rsp.full);
        end
      end
      if (req_i.valid && req_i.ready) begin
        predict_slot_op(req_i.func, req_i.channel_mask, req_i.slot_index,
                        req_i.frame_length, next_rsp);
        awaited_rsp_q.push_back(next_rsp);
      end
      outstanding_o <= awaited_rsp_q.size();
      mismatch_o <= fail_total;
    end
  end

endmodule

// ===== sim/tb_aged_message_slot_table_top.sv =====
module tb_aged_message_slot_table_top;
  import amst_pkg::*;

  localparam logic [APB_AW-1:0]  MAX_LEN_ADDR = {REG_MAX_LEN, 2'b00};
  localparam logic [FUNC_W-1:0]  FN_UNUSED_LO = 4'd9;
  localparam logic [FUNC_W-1:0]  FN_UNUSED_HI = 4'd15;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [APB_AW-1:0]  paddr = '0;
  logic [APB_DW-1:0]  pwdata = '0;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  logic               idle_en = 1'b1;
  int                 stall_left = 0;
  logic [LEN_W-1:0]   limit_now = MAX_LEN_RESET;
  int                 mismatches;
  int                 outstanding;

  amst_req_if req_if ();
  amst_rsp_if rsp_if ();

  aged_message_slot_table_top DUT (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .req_i     (req_if),
    .rsp_o     (rsp_if),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready)
  );

  amst_slot_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .req_i         (req_if),
    .rsp_i         (rsp_if),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .pready_i      (pready),
    .mismatch_o    (mismatches),
    .outstanding_o (outstanding)
  );

  always #6 clk = ~clk;

  // stall the result channel in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rsp_if.ready <= (stall_left == 1);
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 13);
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  task automatic push_request(input logic [FUNC_W-1:0] f, input logic [MASK_W-1:0] m,
                              input logic [INDEX_W-1:0] s, input logic [LEN_W-1:0] l);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.func         <= f;
    req_if.channel_mask <= m;
    req_if.slot_index   <= s;
    req_if.frame_length <= l;
    do @(posedge clk); while (!req_if.ready);
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_len_limit(input logic [LEN_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MAX_LEN_ADDR;
    pwdata  <= APB_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    limit_now = value;
  endtask

  function automatic logic [MASK_W-1:0] pick_mask();
    logic [MASK_W-1:0] m;
    case ($urandom_range(0, 4))
      0, 1:    m = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
      2:       m = MASK_W'($urandom_range(0, 65535));
      3:       m = '1;
      default: m = '0;
    endcase
    return m;
  endfunction

  task automatic push_random_request();
    int                  pick;
    logic [FUNC_W-1:0]   f;
    logic [LEN_W-1:0]    l;
    pick = $urandom_range(0, 99);
    l = LEN_W'($urandom_range(0, 255));
    if (pick < 36) begin
      f = FUNC_W'($urandom_range(FN_ADD_NET_AGE, FN_ADD_DATA));
      if ($urandom_range(0, 5) != 0) l = LEN_W'($urandom_range(0, limit_now));
    end else if (pick < 58) begin
      f = ($urandom_range(0, 1) == 0) ? FN_FIND_NET : FN_FIND_DATA;
    end else if (pick < 72) begin
      f = ($urandom_range(0, 1) == 0) ? FN_SET_CH : FN_CLEAR_CH;
    end else if (pick < 80) begin
      f = FN_ERASE;
    end else if (pick < 95) begin
      f = FN_AGE;
    end else begin
      f = FUNC_W'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
    end
    push_request(f, pick_mask(), INDEX_W'($urandom_range(0, SLOTS - 1)), l);
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.func = '0;
    req_if.channel_mask = '0;
    req_if.slot_index = '0;
    req_if.frame_length = '0;
    rsp_if.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_request(FN_FIND_NET, 16'hFFFF, 4'd0, 8'd0);
    push_request(FN_FIND_DATA, 16'hFFFF, 4'd0, 8'd0);
    push_request(FN_ADD_NET, 16'h0001, 4'd0, 8'd0);
    push_request(FN_ADD_DATA, 16'h8000, 4'd15, 8'd32);
    push_request(FN_ADD_NET, 16'hFFFF, 4'd0, 8'd33);
    push_request(FN_ADD_DATA, 16'hFFFF, 4'd0, 8'd255);
    push_request(FN_ADD_NET_AGE, 16'hFFFF, 4'd0, 8'd0);
    push_request(FN_FIND_NET, 16'h0001, 4'd0, 8'd0);
    push_request(FN_FIND_NET, 16'h0000, 4'd0, 8'd0);
    push_request(FN_FIND_DATA, 16'h8000, 4'd0, 8'd0);
    push_request(FN_SET_CH, 16'hAAAA, 4'd15, 8'd0);
    push_request(FN_CLEAR_CH, 16'hFFFF, 4'd0, 8'd0);
    push_request(FN_ERASE, 16'h0000, 4'd15, 8'd0);
    push_request(FN_ERASE, 16'hFFFF, 4'd1, 8'd0);
    push_request(FN_AGE, 16'h0000, 4'd0, 8'd0);
    push_request(FN_FIND_DATA, 16'hFFFF, 4'd0, 8'd0);
    push_request(FN_FIND_NET, 16'h5555, 4'd0, 8'd0);
    push_request(FN_UNUSED_LO, 16'hFFFF, 4'd15, 8'd255);
    push_request(FN_UNUSED_HI, 16'h0000, 4'd0, 8'd0);
    drain_results();

    write_len_limit(8'd0);
    repeat (200) push_random_request();
    drain_results();

    write_len_limit(8'd255);
    repeat (250) push_random_request();
    drain_results();

    write_len_limit(LEN_W'($urandom_range(1, 254)));
    repeat (250) push_random_request();
    drain_results();

    // run the last part at full rate
    write_len_limit(MAX_LEN_RESET);
    idle_en = 1'b0;
    repeat (250) push_random_request();
    drain_results();

    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("[aged_message_slot_table_top] OK");
    end else begin
      $display("[aged_message_slot_table_top] ERROR");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("[aged_message_slot_table_top] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
sv/amst_pkg.sv
sv/amst_if.sv
sv/aged_message_slot_table_top.sv
sim/amst_slot_checker.sv
sim/tb_aged_message_slot_table_top.sv
